/* sv/dmx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dmx_pkg;

    localparam int MAX_PEERS = 64;
    localparam int ID_BITS   = 6;
    localparam int SEQ_BITS  = 16;

    // Peer count holds 0..MAX_PEERS, the walk index only 0..MAX_PEERS-1.
    localparam int CNT_W    = $clog2(MAX_PEERS + 1);
    localparam int PTR_W    = $clog2(MAX_PEERS);
    localparam int ID_SPACE = 1 << ID_BITS;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_OWN_ID = 3'd0;

    typedef enum logic [2:0] {
        OP_LOCAL_REQ = 3'd0,
        OP_IN_REQ    = 3'd1,
        OP_IN_REPLY  = 3'd2,
        OP_RELEASE   = 3'd3,
        OP_ADD_PEER  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_GRANT   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REQ_RD,
        ST_REQ_USE,
        ST_REL_RD,
        ST_REL_USE,
        ST_REL_FLUSH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* sv/dmx_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Event channel into the agent.
interface dmx_evt_if
    import dmx_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [ID_BITS-1:0]  peer_id;
    logic [SEQ_BITS-1:0] seq_in;

    modport source (output valid, opcode, peer_id, seq_in, input ready);
    modport sink   (input valid, opcode, peer_id, seq_in, output ready);
endinterface

// Message channel out of the agent.
interface dmx_msg_if
    import dmx_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [ID_BITS-1:0]  dest_id;
    logic [SEQ_BITS-1:0] seq_out;
    logic                last;

    modport source (output valid, kind, dest_id, seq_out, last, input ready);
    modport sink   (input valid, kind, dest_id, seq_out, last, output ready);
endinterface

`default_nettype wire

/* sv/distributed_mutex_agent.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                            Handshake
// evt       in         opcode, peer_id, seq_in            valid/ready
// msg       out        kind, dest_id, seq_out, last       valid/ready
// apb       config     own_id at byte address 0           psel/penable, pready=1
//
// An item is taken only when the sequencer is idle; it then enters the dispatch state.
// Local request and local release walk the peer table with a read and a use state per
// entry, set by the registered read port of the peer memory; a release ends with a
// flush state. Other opcodes return to idle from dispatch or via the emit state.
// Reset clears all control state, the counters, the sequence numbers and the deferred marks;
// the peer table itself is not cleared, since only entries below the peer count are read.
// A stalled message output holds the sequencer wherever a new message would be produced.

module distributed_mutex_agent
    import dmx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    dmx_evt_if.sink                 evt,
    dmx_msg_if.source               msg,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Sequencer and latched item.
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_BITS-1:0]  pid_reg, pid_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;

    // Protocol state.
    logic [ID_BITS-1:0]  own_id_reg;
    logic [CNT_W-1:0]    peer_count_reg, peer_count_next;
    logic [ID_SPACE-1:0] marks_reg, marks_next;
    logic [SEQ_BITS-1:0] highest_reg, highest_next;
    logic [SEQ_BITS-1:0] own_seq_reg, own_seq_next;
    logic [CNT_W-1:0]    pending_reg, pending_next;
    logic                requesting_reg, requesting_next;

    // Table walk.
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [ID_BITS-1:0]  tab_q_reg;
    logic                hold_valid_reg, hold_valid_next;
    logic [ID_BITS-1:0]  hold_id_reg, hold_id_next;

    // Single result for the short opcodes.
    kind_t               res_kind_reg, res_kind_next;
    logic [ID_BITS-1:0]  res_dest_reg, res_dest_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [ID_BITS-1:0]  out_dest_reg, out_dest_next;
    logic [SEQ_BITS-1:0] out_seq_reg, out_seq_next;
    logic                out_last_reg, out_last_next;

    logic [ID_BITS-1:0]  peer_mem [MAX_PEERS];
    logic                tab_we;

    logic                slot_free;
    logic                walk_end;
    logic                emit;
    kind_t               e_kind;
    logic [ID_BITS-1:0]  e_dest;
    logic [SEQ_BITS-1:0] e_seq;
    logic                e_last;
    logic                defer;
    logic                cfg_hit;

    // Configuration port. The only register is own_id.
    assign cfg_hit = (paddr == ADDR_OWN_ID);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? PDATA_W'(own_id_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            own_id_reg <= pwdata[ID_BITS-1:0];
        end
    end

    // Peer table: written on an add, read once per cycle at the walk index.
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            peer_mem[peer_count_reg[PTR_W-1:0]] <= pid_reg;
        end
        tab_q_reg <= peer_mem[idx_reg];
    end

    assign evt.ready     = (state_reg == ST_IDLE);
    assign msg.valid     = out_valid_reg;
    assign msg.kind      = out_kind_reg;
    assign msg.dest_id   = out_dest_reg;
    assign msg.seq_out   = out_seq_reg;
    assign msg.last      = out_last_reg;

    // A new message may be loaded when the output register is empty or is drained now.
    assign slot_free = !out_valid_reg || msg.ready;
    assign walk_end  = ({1'b0, idx_reg} == CNT_W'(peer_count_reg - 1'b1));

    // An incoming request loses to our own pending request on the (seq, id) order.
    assign defer = requesting_reg &&
                   ((seq_reg > own_seq_reg) ||
                    ((seq_reg == own_seq_reg) && (pid_reg > own_id_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            peer_count_reg <= '0;
            marks_reg      <= '0;
            highest_reg    <= '0;
            own_seq_reg    <= '0;
            pending_reg    <= '0;
            requesting_reg <= 1'b0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            peer_count_reg <= peer_count_next;
            marks_reg      <= marks_next;
            highest_reg    <= highest_next;
            own_seq_reg    <= own_seq_next;
            pending_reg    <= pending_next;
            requesting_reg <= requesting_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pid_reg      <= pid_next;
        seq_reg      <= seq_next;
        hold_id_reg  <= hold_id_next;
        res_kind_reg <= res_kind_next;
        res_dest_reg <= res_dest_next;
        out_kind_reg <= out_kind_next;
        out_dest_reg <= out_dest_next;
        out_seq_reg  <= out_seq_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        seq_next        = seq_reg;
        peer_count_next = peer_count_reg;
        marks_next      = marks_reg;
        highest_next    = highest_reg;
        own_seq_next    = own_seq_reg;
        pending_next    = pending_reg;
        requesting_next = requesting_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        res_kind_next   = res_kind_reg;
        res_dest_next   = res_dest_reg;
        tab_we          = 1'b0;
        emit            = 1'b0;
        e_kind          = KIND_REPLY;
        e_dest          = '0;
        e_seq           = '0;
        e_last          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    op_next    = op_t'(evt.opcode);
                    pid_next   = evt.peer_id;
                    seq_next   = evt.seq_in;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    OP_LOCAL_REQ:
                    begin
                        // The highest number saturates rather than wrapping.
                        requesting_next = 1'b1;
                        if (highest_reg != '1)
                        begin
                            highest_next = SEQ_BITS'(highest_reg + 1'b1);
                        end
                        own_seq_next = highest_next;
                        pending_next = peer_count_reg;
                        idx_next     = '0;
                        if (peer_count_reg == '0)
                        begin
                            res_kind_next = KIND_GRANT;
                            res_dest_next = '0;
                            state_next    = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_REQ_RD;
                        end
                    end
                    OP_IN_REQ:
                    begin
                        if (seq_reg > highest_reg)
                        begin
                            highest_next = seq_reg;
                        end
                        if (defer)
                        begin
                            marks_next[pid_reg] = 1'b1;
                        end
                        else
                        begin
                            res_kind_next = KIND_REPLY;
                            res_dest_next = pid_reg;
                            state_next    = ST_EMIT;
                        end
                    end
                    OP_IN_REPLY:
                    begin
                        // A stray reply with nothing outstanding is dropped.
                        if (pending_reg != '0)
                        begin
                            pending_next = CNT_W'(pending_reg - 1'b1);
                            if (pending_reg == CNT_W'(1))
                            begin
                                res_kind_next = KIND_GRANT;
                                res_dest_next = '0;
                                state_next    = ST_EMIT;
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        requesting_next = 1'b0;
                        idx_next        = '0;
                        hold_valid_next = 1'b0;
                        if (peer_count_reg != '0)
                        begin
                            state_next = ST_REL_RD;
                        end
                    end
                    OP_ADD_PEER:
                    begin
                        if (peer_count_reg != CNT_W'(MAX_PEERS))
                        begin
                            tab_we              = 1'b1;
                            marks_next[pid_reg] = 1'b0;
                            peer_count_next     = CNT_W'(peer_count_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_REQ_RD:
            begin
                state_next = ST_REQ_USE;
            end

            ST_REQ_USE:
            begin
                if (slot_free)
                begin
                    emit   = 1'b1;
                    e_kind = KIND_REQUEST;
                    e_dest = tab_q_reg;
                    e_seq  = own_seq_reg;
                    e_last = walk_end;
                    if (walk_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = PTR_W'(idx_reg + 1'b1);
                        state_next = ST_REQ_RD;
                    end
                end
            end

            ST_REL_RD:
            begin
                state_next = ST_REL_USE;
            end

            ST_REL_USE:
            begin
                // Each found reply waits for the next or the flush, so the last is flagged.
                if (!(marks_reg[tab_q_reg] && hold_valid_reg && !slot_free))
                begin
                    if (marks_reg[tab_q_reg])
                    begin
                        if (hold_valid_reg)
                        begin
                            emit   = 1'b1;
                            e_kind = KIND_REPLY;
                            e_dest = hold_id_reg;
                        end
                        marks_next[tab_q_reg] = 1'b0;
                        hold_valid_next       = 1'b1;
                        hold_id_next          = tab_q_reg;
                    end
                    if (walk_end)
                    begin
                        state_next = ST_REL_FLUSH;
                    end
                    else
                    begin
                        idx_next   = PTR_W'(idx_reg + 1'b1);
                        state_next = ST_REL_RD;
                    end
                end
            end

            ST_REL_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    emit            = 1'b1;
                    e_kind          = KIND_REPLY;
                    e_dest          = hold_id_reg;
                    e_last          = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_kind     = res_kind_reg;
                    e_dest     = res_dest_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded on emit, emptied when the sink takes the item.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_dest_next  = out_dest_reg;
        out_seq_next   = out_seq_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = e_kind;
            out_dest_next  = e_dest;
            out_seq_next   = e_seq;
            out_last_next  = e_last;
        end
        else if (msg.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peer_count_reg <= CNT_W'(MAX_PEERS))
        else $error("peer count beyond table capacity");

    // Outstanding replies never exceed the peers asked.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= peer_count_reg)
        else $error("more replies pending than peers");

    // A walk only visits entries that have been written.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REQ_USE || state_reg == ST_REL_USE) |->
        ({1'b0, idx_reg} < peer_count_reg))
        else $error("table walk past the peer count");

    // A held-back reply exists only during a release walk.
    a_hold_scope: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |->
        (state_reg == ST_REL_RD || state_reg == ST_REL_USE || state_reg == ST_REL_FLUSH))
        else $error("held reply outside a release walk");

    // Loading a message never overwrites one the sink has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !msg.ready) |=> $stable(out_dest_reg) && $stable(out_last_reg))
        else $error("pending message overwritten");

endmodule

`default_nettype wire
